// ===== src/nfc_card_presence_sequencer_top_assert.svh =====
// Assertion macros for the card presence sequencer top level.
// Included by nfc_card_presence_sequencer_top.sv; needs no package.
`ifndef NFC_CARD_PRESENCE_SEQUENCER_TOP_ASSERT_SVH
`define NFC_CARD_PRESENCE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NFC_CPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NFC_CPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nfc_cps_pkg.sv =====
// Shared types, codes and helpers for the card presence sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package nfc_cps_pkg;

    typedef enum logic [1:0] {
        MODE_WAKE   = 2'd0,
        MODE_POLL   = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_ARM        = 3'd1,
        ACT_POLL       = 3'd2,
        ACT_MEASURE    = 3'd3,
        ACT_POWER_DOWN = 3'd4
    } action_t;

    typedef enum logic [6:0] {
        PH_WAIT_WAKE      = 7'b0000001,
        PH_FIRST_POLL     = 7'b0000010,
        PH_CONFIRM_WAIT   = 7'b0000100,
        PH_CONFIRM_POLL   = 7'b0001000,
        PH_WATCH_SAMPLE   = 7'b0010000,
        PH_REMOVAL_WAIT   = 7'b0100000,
        PH_REMOVAL_SAMPLE = 7'b1000000
    } phase_t;

    // Phase numbers as reported on the result channel
    localparam logic [2:0] PHN_WAIT_WAKE      = 3'd0;
    localparam logic [2:0] PHN_FIRST_POLL     = 3'd1;
    localparam logic [2:0] PHN_CONFIRM_WAIT   = 3'd2;
    localparam logic [2:0] PHN_CONFIRM_POLL   = 3'd3;
    localparam logic [2:0] PHN_WATCH_SAMPLE   = 3'd4;
    localparam logic [2:0] PHN_REMOVAL_WAIT   = 3'd5;
    localparam logic [2:0] PHN_REMOVAL_SAMPLE = 3'd6;
    localparam logic [2:0] PHN_UNUSED         = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] CFG_AMP_REF          = 3'd0;
    localparam logic [2:0] CFG_WAKE_DELTA       = 3'd1;
    localparam logic [2:0] CFG_QUIET_DELTA      = 3'd2;
    localparam logic [2:0] CFG_CONFIRM_RETRIES  = 3'd3;
    localparam logic [2:0] CFG_CONFIRM_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_RECHECK_INTERVAL = 3'd5;
    localparam logic [2:0] CFG_STABLE_NEEDED    = 3'd6;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    // Register reset values
    localparam logic [7:0]  RST_AMP_REF          = 8'd0;
    localparam logic [7:0]  RST_WAKE_DELTA       = 8'd3;
    localparam logic [7:0]  RST_QUIET_DELTA      = 8'd1;
    localparam logic [2:0]  RST_CONFIRM_RETRIES  = 3'd5;
    localparam logic [15:0] RST_CONFIRM_INTERVAL = 16'd40;
    localparam logic [15:0] RST_RECHECK_INTERVAL = 16'd100;
    localparam logic [1:0]  RST_STABLE_NEEDED    = 2'd3;

    localparam int          WAKE_FLAG_IDX = 2;
    localparam logic [1:0]  STABLE_MAX    = 2'd3;

    typedef struct packed {
        logic [7:0]  amp_ref;
        logic [7:0]  wake_delta;
        logic [7:0]  quiet_delta;
        logic [2:0]  confirm_retries;
        logic [15:0] confirm_interval;
        logic [15:0] recheck_interval;
        logic [1:0]  stable_needed;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] irq_flags;
        logic       card_found;
        logic       sample_valid;
        logic [7:0] amplitude;
    } event_t;

    typedef struct packed {
        action_t    action;
        logic [2:0] phase_out;
        logic       card_removed;
    } result_t;

    function automatic logic [2:0] phase_num(input phase_t p);
        logic [2:0] n;
        unique case (p)
            PH_WAIT_WAKE:      n = PHN_WAIT_WAKE;
            PH_FIRST_POLL:     n = PHN_FIRST_POLL;
            PH_CONFIRM_WAIT:   n = PHN_CONFIRM_WAIT;
            PH_CONFIRM_POLL:   n = PHN_CONFIRM_POLL;
            PH_WATCH_SAMPLE:   n = PHN_WATCH_SAMPLE;
            PH_REMOVAL_WAIT:   n = PHN_REMOVAL_WAIT;
            PH_REMOVAL_SAMPLE: n = PHN_REMOVAL_SAMPLE;
            default:           n = PHN_UNUSED;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/nfc_card_presence_sequencer_top.sv =====
// Card presence sequencer: wake-up detection, confirmation polling and
// removal watching for an NFC front end, one action per event.
// Use:
//   s_ channel carries events. s_tuser[1:0] is the event kind (0 wake
//   interrupt, 1 poll outcome, 2 amplitude sample, 3 tick); s_tdata holds
//   the flag byte, poll and sample status and the amplitude sample.
//   m_ channel returns one result per event: action code, phase after the
//   event and the removal pulse.
//   cfg_wr_en/cfg_addr/cfg_wr_data write the seven threshold and interval
//   registers; write them only while no event is in flight.
// Timing:
//   An accepted event is held in the input register; once the result
//   register has room, its result moves in on the next edge, raising
//   m_tvalid. One event per cycle is taken continuously while m_tready
//   stays high; the single pass through the phase logic sets that rate.
//   If the master stalls, the result register holds; one more event waits in
//   the input register, then s_tready drops until the result is taken.
// Reset:
//   aresetn low (synchronous) empties both registers, returns the phase to
//   waiting for wake-up, clears all counters and loads register defaults.
`default_nettype none

module nfc_card_presence_sequencer_top
    import nfc_cps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] irq_flags, [8] card_found, [9] sample_valid, [17:10] amplitude
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [2:0] action, [5:3] phase_out, [6] card_removed
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

`include "nfc_card_presence_sequencer_top_assert.svh"

    cfg_t    cfg;
    event_t  ev;
    result_t result;
    logic    ev_valid;
    logic    out_free;
    logic    advance;
    logic    out_removed;
    logic    out_rearm;
    logic    both_full;

    // Move the held event into the result register when there is room
    assign advance = ev_valid && out_free;

    nfc_cps_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    nfc_cps_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    nfc_cps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .ev      (ev),
        .advance (advance),
        .result  (result)
    );

    nfc_cps_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign out_removed = m_tvalid && m_tdata[6];
    assign out_rearm   = (m_tdata[2:0] == ACT_ARM) && (m_tdata[5:3] == PHN_WAIT_WAKE);
    assign both_full   = ev_valid && m_tvalid && !m_tready;

    `NFC_CPS_ASSERT_SAME(a_removed_rearms, aclk, aresetn, out_removed, out_rearm, "no re-arm")
    `NFC_CPS_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, m_tvalid, "result lost")
    `NFC_CPS_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, both_full, !s_tready, "taken when full")

endmodule

`default_nettype wire

// ===== src/nfc_cps_cfg.sv =====
// Configuration register bank of the card presence sequencer.
// Depends on nfc_cps_pkg for register indexes and reset values.
`default_nettype none

module nfc_cps_cfg
    import nfc_cps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AMP_REF:          cfg_next.amp_ref          = cfg_wr_data[7:0];
                CFG_WAKE_DELTA:       cfg_next.wake_delta       = cfg_wr_data[7:0];
                CFG_QUIET_DELTA:      cfg_next.quiet_delta      = cfg_wr_data[7:0];
                CFG_CONFIRM_RETRIES:  cfg_next.confirm_retries  = cfg_wr_data[2:0];
                CFG_CONFIRM_INTERVAL: cfg_next.confirm_interval = cfg_wr_data;
                CFG_RECHECK_INTERVAL: cfg_next.recheck_interval = cfg_wr_data;
                CFG_STABLE_NEEDED:    cfg_next.stable_needed    = cfg_wr_data[1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.amp_ref          <= RST_AMP_REF;
            cfg_reg.wake_delta       <= RST_WAKE_DELTA;
            cfg_reg.quiet_delta      <= RST_QUIET_DELTA;
            cfg_reg.confirm_retries  <= RST_CONFIRM_RETRIES;
            cfg_reg.confirm_interval <= RST_CONFIRM_INTERVAL;
            cfg_reg.recheck_interval <= RST_RECHECK_INTERVAL;
            cfg_reg.stable_needed    <= RST_STABLE_NEEDED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/nfc_cps_in_stage.sv =====
// Input register of the card presence sequencer: unpacks and holds one event.
// Depends on nfc_cps_pkg for the event struct.
`default_nettype none

module nfc_cps_in_stage
    import nfc_cps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 advance,
    output logic                      ev_valid,
    output event_t                    ev
);

    logic   valid_reg;
    logic   valid_next;
    event_t ev_reg;
    logic   accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ev_reg.mode         <= mode_t'(s_tuser);
            ev_reg.irq_flags    <= s_tdata[7:0];
            ev_reg.card_found   <= s_tdata[8];
            ev_reg.sample_valid <= s_tdata[9];
            ev_reg.amplitude    <= s_tdata[17:10];
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

`default_nettype wire

// ===== src/nfc_cps_core.sv =====
// Phase machine of the card presence sequencer: state registers plus the
// one-pass next-state and action logic. Depends on nfc_cps_pkg.
`default_nettype none

module nfc_cps_core
    import nfc_cps_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire event_t ev,
    input  wire logic   advance,
    output result_t     result
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] countdown_reg;
    logic [15:0] countdown_next;
    logic [2:0]  retry_count_reg;
    logic [2:0]  retry_count_next;
    logic [1:0]  stable_count_reg;
    logic [1:0]  stable_count_next;

    logic [7:0]  diff;
    logic        calm;
    logic        stable_sample;
    logic        tick_due;
    logic [15:0] countdown_dec;
    logic [1:0]  stable_inc;
    logic [1:0]  stable_new;
    logic [1:0]  need;
    action_t     action;
    logic        removed;

    assign diff = (ev.amplitude > cfg.amp_ref) ? ev.amplitude - cfg.amp_ref
                                               : cfg.amp_ref - ev.amplitude;
    assign calm          = ev.sample_valid && (diff < cfg.wake_delta);
    assign stable_sample = diff <= cfg.quiet_delta;
    assign tick_due      = countdown_reg <= 16'd1;
    assign countdown_dec = countdown_reg - 16'd1;
    assign stable_inc    = (stable_count_reg < STABLE_MAX) ? stable_count_reg + 2'd1
                                                           : stable_count_reg;
    assign stable_new    = (ev.sample_valid && stable_sample) ? stable_inc : 2'd0;
    assign need          = (cfg.stable_needed == 2'd0) ? 2'd1 : cfg.stable_needed;

    always_comb begin
        phase_next        = phase_reg;
        countdown_next    = countdown_reg;
        retry_count_next  = retry_count_reg;
        stable_count_next = stable_count_reg;
        action            = ACT_NONE;
        removed           = 1'b0;

        unique case (phase_reg)
            PH_WAIT_WAKE: begin
                if (ev.mode == MODE_WAKE) begin
                    if (ev.irq_flags[WAKE_FLAG_IDX]) begin
                        phase_next = PH_FIRST_POLL;
                        action     = ACT_POLL;
                    end else begin
                        countdown_next = 16'd0;
                        action         = ACT_ARM;
                    end
                end
            end
            PH_FIRST_POLL: begin
                if (ev.mode == MODE_POLL) begin
                    priority if (ev.card_found) begin
                        phase_next        = PH_REMOVAL_WAIT;
                        stable_count_next = 2'd0;
                        countdown_next    = 16'd0;
                        action            = ACT_POWER_DOWN;
                    end else if (!ev.sample_valid || calm) begin
                        phase_next     = PH_WAIT_WAKE;
                        countdown_next = 16'd0;
                        action         = ACT_ARM;
                    end else begin
                        retry_count_next = 3'd0;
                        phase_next       = PH_CONFIRM_WAIT;
                        countdown_next   = 16'd0;
                        action           = ACT_POWER_DOWN;
                    end
                end
            end
            PH_CONFIRM_WAIT: begin
                if (ev.mode == MODE_TICK) begin
                    if (!tick_due) begin
                        countdown_next = countdown_dec;
                    end else if (retry_count_reg < cfg.confirm_retries) begin
                        countdown_next   = 16'd0;
                        retry_count_next = retry_count_reg + 3'd1;
                        phase_next       = PH_CONFIRM_POLL;
                        action           = ACT_POLL;
                    end else begin
                        countdown_next = cfg.recheck_interval;
                        phase_next     = PH_WATCH_SAMPLE;
                        action         = ACT_MEASURE;
                    end
                end
            end
            PH_CONFIRM_POLL: begin
                if (ev.mode == MODE_POLL) begin
                    priority if (ev.card_found) begin
                        phase_next        = PH_REMOVAL_WAIT;
                        stable_count_next = 2'd0;
                        countdown_next    = 16'd0;
                        action            = ACT_POWER_DOWN;
                    end else if (calm) begin
                        phase_next     = PH_WAIT_WAKE;
                        countdown_next = 16'd0;
                        action         = ACT_ARM;
                    end else begin
                        countdown_next = cfg.confirm_interval;
                        phase_next     = PH_CONFIRM_WAIT;
                        action         = ACT_POWER_DOWN;
                    end
                end
            end
            PH_WATCH_SAMPLE: begin
                if (ev.mode == MODE_SAMPLE) begin
                    if (calm) begin
                        phase_next     = PH_WAIT_WAKE;
                        countdown_next = 16'd0;
                        action         = ACT_ARM;
                    end else begin
                        phase_next = PH_CONFIRM_WAIT;
                    end
                end
            end
            PH_REMOVAL_WAIT: begin
                if (ev.mode == MODE_TICK) begin
                    if (tick_due) begin
                        countdown_next = cfg.recheck_interval;
                        phase_next     = PH_REMOVAL_SAMPLE;
                        action         = ACT_MEASURE;
                    end else begin
                        countdown_next = countdown_dec;
                    end
                end
            end
            PH_REMOVAL_SAMPLE: begin
                if (ev.mode == MODE_SAMPLE) begin
                    stable_count_next = stable_new;
                    if (ev.sample_valid && (stable_new >= need)) begin
                        removed        = 1'b1;
                        phase_next     = PH_WAIT_WAKE;
                        countdown_next = 16'd0;
                        action         = ACT_ARM;
                    end else begin
                        phase_next = PH_REMOVAL_WAIT;
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT_WAKE;
            countdown_reg    <= 16'd0;
            retry_count_reg  <= 3'd0;
            stable_count_reg <= 2'd0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            countdown_reg    <= countdown_next;
            retry_count_reg  <= retry_count_next;
            stable_count_reg <= stable_count_next;
        end
    end

    assign result.action       = action;
    assign result.phase_out    = phase_num(phase_next);
    assign result.card_removed = removed;

endmodule

`default_nettype wire

// ===== src/nfc_cps_out_stage.sv =====
// Result register of the card presence sequencer: holds one result
// until the master side takes it. Depends on nfc_cps_pkg.
`default_nettype none

module nfc_cps_out_stage
    import nfc_cps_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire result_t              result,
    output logic                      out_free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held transaction leaves this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, result_reg.card_removed, result_reg.phase_out,
                       result_reg.action};

endmodule

`default_nettype wire
